// File: hw/rtl/drc_pkg.sv
// Shared widths, codes and defaults of the dirty rectangle coalescer.
package drc_pkg;

   // Defaults of the top level parameters.
   localparam int MAX_RECTS_DEF  = 16;
   localparam int COORD_BITS_DEF = 12;

   // Fixed widths of the port fields.
   localparam int IN_COORD_W  = 16;
   localparam int OUT_COORD_W = 12;
   localparam int STATUS_W    = 3;
   localparam int INDEX_W     = 4;
   localparam int COUNT_W     = 5;
   localparam int CSR_DATA_W  = 12;
   localparam int CSR_ADDR_W  = 1;

   // Register indexes.
   localparam logic [CSR_ADDR_W-1:0] CSR_SCREEN_WIDTH  = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SCREEN_HEIGHT = 1'b1;

   // Register reset values.
   localparam logic [CSR_DATA_W-1:0] SCREEN_WIDTH_RESET  = 12'd640;
   localparam logic [CSR_DATA_W-1:0] SCREEN_HEIGHT_RESET = 12'd480;

   // Command codes.
   localparam logic CMD_ADD   = 1'b0;
   localparam logic CMD_DRAIN = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DROPPED     = 3'd0,
      STATUS_MERGED      = 3'd1,
      STATUS_APPENDED    = 3'd2,
      STATUS_OVERFLOW    = 3'd3,
      STATUS_DRAINED     = 3'd4,
      STATUS_DRAIN_EMPTY = 3'd5
   } status_type;

   typedef enum logic [4:0] {
      ST_IDLE        = 5'b00001,
      ST_CLIP        = 5'b00010,
      ST_SCAN        = 5'b00100,
      ST_DRAIN_START = 5'b01000,
      ST_DRAIN       = 5'b10000
   } state_type;

endpackage

// File: hw/rtl/dirty_rectangle_coalescer.sv
// Top level of the dirty rectangle coalescer: sequencer, screen registers and result word.
//
//   channel   ports                              handshake
//   request   req_cmd, req_in_left..req_in_bottom start high while busy low
//   response  rsp_status..rsp_last               rsp_valid for one cycle
//   config    csr_addr, csr_wdata                csr_we, no wait
//
// An add reads stored entries one by one until a hit or the end of the list; a dropped
// add or an add to an empty list reads none.
// A drain reads every stored entry and emits one word a cycle.
// The single read port of the store reads one entry per cycle.
// Reset empties the list and loads the default screen size; the store is not cleared.
// The receiver cannot stall; each response word is shown for exactly one cycle.
module dirty_rectangle_coalescer import drc_pkg::*; #(
   parameter int MAX_RECTS  = MAX_RECTS_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_cmd,
   input  logic signed [IN_COORD_W-1:0] req_in_left,
   input  logic signed [IN_COORD_W-1:0] req_in_top,
   input  logic signed [IN_COORD_W-1:0] req_in_right,
   input  logic signed [IN_COORD_W-1:0] req_in_bottom,
   output logic                         rsp_valid,
   output logic [STATUS_W-1:0]          rsp_status,
   output logic [INDEX_W-1:0]           rsp_entry_index,
   output logic [OUT_COORD_W-1:0]       rsp_out_left,
   output logic [OUT_COORD_W-1:0]       rsp_out_top,
   output logic [OUT_COORD_W-1:0]       rsp_out_right,
   output logic [OUT_COORD_W-1:0]       rsp_out_bottom,
   output logic [COUNT_W-1:0]           rsp_entry_count,
   output logic                         rsp_last,
   input  logic                         csr_we,
   input  logic [CSR_ADDR_W-1:0]        csr_addr,
   input  logic [CSR_DATA_W-1:0]        csr_wdata
);

   localparam int IDX_W = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
   localparam int CNT_W = $clog2(MAX_RECTS + 1);
   localparam int BOX_W = 4 * COORD_BITS;

   state_type state_ff, state_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [COORD_BITS-1:0] width_ff, width_in, height_ff, height_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            status_ff, status_in;
   logic [IDX_W-1:0]      index_ff, index_in;
   logic [BOX_W-1:0]      box_ff, box_in;
   logic [CNT_W-1:0]      count_out_ff, count_out_in;
   logic                  last_ff, last_in;

   logic                  clip_load, clip_empty;
   logic [COORD_BITS-1:0] c_l, c_t, c_r, c_b;
   logic [COORD_BITS-1:0] d_l, d_t, d_r, d_b;
   logic [COORD_BITS-1:0] m_l, m_t, m_r, m_b;
   logic [BOX_W-1:0]      clip_box, merged_box;

   logic                  mem_we, mem_re;
   logic [IDX_W-1:0]      mem_waddr, mem_raddr;
   logic [BOX_W-1:0]      mem_wdata, mem_rdata;

   logic                  hit, scan_end, full;

   drc_clip #(
      .COORD_BITS(COORD_BITS)
   ) u_clip (
      .clock        (clock),
      .load         (clip_load),
      .in_left      (req_in_left),
      .in_top       (req_in_top),
      .in_right     (req_in_right),
      .in_bottom    (req_in_bottom),
      .screen_width (width_ff),
      .screen_height(height_ff),
      .clip_left    (c_l),
      .clip_top     (c_t),
      .clip_right   (c_r),
      .clip_bottom  (c_b),
      .empty        (clip_empty)
   );

   drc_rect_mem #(
      .DEPTH (MAX_RECTS),
      .WIDTH (BOX_W),
      .ADDR_W(IDX_W)
   ) u_mem (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(mem_waddr),
      .wr_data(mem_wdata),
      .rd_en  (mem_re),
      .rd_addr(mem_raddr),
      .rd_data(mem_rdata)
   );

   // Stored boxes are packed left, top, right, bottom from the top bit down.
   assign d_l = mem_rdata[4*COORD_BITS-1 -: COORD_BITS];
   assign d_t = mem_rdata[3*COORD_BITS-1 -: COORD_BITS];
   assign d_r = mem_rdata[2*COORD_BITS-1 -: COORD_BITS];
   assign d_b = mem_rdata[COORD_BITS-1 -: COORD_BITS];

   // Edges that only touch do not count as overlap.
   assign hit = (d_l < c_r) && (c_l < d_r) && (d_t < c_b) && (c_t < d_b);

   assign m_l = (c_l < d_l) ? c_l : d_l;
   assign m_t = (c_t < d_t) ? c_t : d_t;
   assign m_r = (c_r > d_r) ? c_r : d_r;
   assign m_b = (c_b > d_b) ? c_b : d_b;

   assign clip_box   = {c_l, c_t, c_r, c_b};
   assign merged_box = {m_l, m_t, m_r, m_b};

   assign scan_end = (CNT_W'(idx_ff) + CNT_W'(1)) == count_ff;
   assign full     = count_ff == CNT_W'(MAX_RECTS);

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         if (csr_addr == CSR_SCREEN_WIDTH) begin
            width_in = COORD_BITS'(csr_wdata);
         end else if (csr_addr == CSR_SCREEN_HEIGHT) begin
            height_in = COORD_BITS'(csr_wdata);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      status_in    = status_ff;
      index_in     = index_ff;
      box_in       = box_ff;
      count_out_in = count_out_ff;
      last_in      = last_ff;
      clip_load    = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = idx_ff;
      mem_wdata    = merged_box;
      mem_re       = 1'b0;
      mem_raddr    = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_cmd == CMD_DRAIN) begin
                  state_in = ST_DRAIN_START;
               end else begin
                  clip_load = 1'b1;
                  state_in  = ST_CLIP;
               end
            end
         end
         ST_CLIP: begin
            if (clip_empty) begin
               rsp_valid_in = 1'b1;
               status_in    = STATUS_DROPPED;
               index_in     = '0;
               box_in       = '0;
               count_out_in = count_ff;
               last_in      = 1'b1;
               state_in     = ST_IDLE;
            end else if (count_ff == '0) begin
               mem_we       = 1'b1;
               mem_waddr    = '0;
               mem_wdata    = clip_box;
               count_in     = CNT_W'(1);
               rsp_valid_in = 1'b1;
               status_in    = STATUS_APPENDED;
               index_in     = '0;
               box_in       = clip_box;
               count_out_in = CNT_W'(1);
               last_in      = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = '0;
               idx_in    = '0;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // Read data holds entry idx_ff; the next read goes out while it is tested.
            if (hit) begin
               mem_we       = 1'b1;
               mem_waddr    = idx_ff;
               mem_wdata    = merged_box;
               rsp_valid_in = 1'b1;
               status_in    = STATUS_MERGED;
               index_in     = idx_ff;
               box_in       = merged_box;
               count_out_in = count_ff;
               last_in      = 1'b1;
               state_in     = ST_IDLE;
            end else if (scan_end) begin
               rsp_valid_in = 1'b1;
               last_in      = 1'b1;
               state_in     = ST_IDLE;
               mem_we       = 1'b1;
               if (!full) begin
                  mem_waddr    = IDX_W'(count_ff);
                  mem_wdata    = clip_box;
                  count_in     = count_ff + CNT_W'(1);
                  status_in    = STATUS_APPENDED;
                  index_in     = IDX_W'(count_ff);
                  box_in       = clip_box;
                  count_out_in = count_ff + CNT_W'(1);
               end else begin
                  // A full list has just read its last slot, so merge into that one.
                  mem_waddr    = IDX_W'(MAX_RECTS - 1);
                  mem_wdata    = merged_box;
                  status_in    = STATUS_OVERFLOW;
                  index_in     = IDX_W'(MAX_RECTS - 1);
                  box_in       = merged_box;
                  count_out_in = count_ff;
               end
            end else begin
               mem_re    = 1'b1;
               mem_raddr = idx_ff + IDX_W'(1);
               idx_in    = idx_ff + IDX_W'(1);
            end
         end
         ST_DRAIN_START: begin
            if (count_ff == '0) begin
               rsp_valid_in = 1'b1;
               status_in    = STATUS_DRAIN_EMPTY;
               index_in     = '0;
               box_in       = '0;
               count_out_in = '0;
               last_in      = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = '0;
               idx_in    = '0;
               state_in  = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            rsp_valid_in = 1'b1;
            status_in    = STATUS_DRAINED;
            index_in     = idx_ff;
            box_in       = mem_rdata;
            count_out_in = '0;
            last_in      = scan_end;
            if (scan_end) begin
               count_in = '0;
               state_in = ST_IDLE;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = idx_ff + IDX_W'(1);
               idx_in    = idx_ff + IDX_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         count_ff     <= '0;
         width_ff     <= COORD_BITS'(SCREEN_WIDTH_RESET);
         height_ff    <= COORD_BITS'(SCREEN_HEIGHT_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         count_ff     <= count_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff    <= status_in;
      index_ff     <= index_in;
      box_ff       <= box_in;
      count_out_ff <= count_out_in;
      last_ff      <= last_in;
   end

   assign busy            = state_ff != ST_IDLE;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_entry_index = INDEX_W'(index_ff);
   assign rsp_out_left    = OUT_COORD_W'(box_ff[4*COORD_BITS-1 -: COORD_BITS]);
   assign rsp_out_top     = OUT_COORD_W'(box_ff[3*COORD_BITS-1 -: COORD_BITS]);
   assign rsp_out_right   = OUT_COORD_W'(box_ff[2*COORD_BITS-1 -: COORD_BITS]);
   assign rsp_out_bottom  = OUT_COORD_W'(box_ff[COORD_BITS-1 -: COORD_BITS]);
   assign rsp_entry_count = COUNT_W'(count_out_ff);
   assign rsp_last        = last_ff;

   // The final word of an item always arrives with the block free again.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> !busy)
      else $error("final response word while still busy");

   // A word that is not the last is part of a drain still in progress.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> (busy && rsp_status == STATUS_DRAINED))
      else $error("intermediate response word outside a drain");

   // Drain results report an empty list.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_DRAINED || rsp_status == STATUS_DRAIN_EMPTY))
      |-> (rsp_entry_count == '0))
      else $error("drain response with nonzero entry count");

   // The list never grows past its capacity.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_RECTS))
      else $error("rectangle count above capacity");

endmodule

// File: hw/rtl/drc_clip.sv
// Clip unit: clamps an incoming rectangle to the screen and flags an empty result.
module drc_clip import drc_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         load,
   input  logic signed [IN_COORD_W-1:0] in_left,
   input  logic signed [IN_COORD_W-1:0] in_top,
   input  logic signed [IN_COORD_W-1:0] in_right,
   input  logic signed [IN_COORD_W-1:0] in_bottom,
   input  logic [COORD_BITS-1:0]        screen_width,
   input  logic [COORD_BITS-1:0]        screen_height,
   output logic [COORD_BITS-1:0]        clip_left,
   output logic [COORD_BITS-1:0]        clip_top,
   output logic [COORD_BITS-1:0]        clip_right,
   output logic [COORD_BITS-1:0]        clip_bottom,
   output logic                         empty
);

   logic [COORD_BITS-1:0] left_ff, top_ff, right_ff, bottom_ff;

   function automatic logic [COORD_BITS-1:0] clamp_edge(
      input logic signed [IN_COORD_W-1:0] v,
      input logic [COORD_BITS-1:0]        hi
   );
      logic signed [IN_COORD_W:0] v_ext;
      logic signed [IN_COORD_W:0] hi_ext;
      logic [COORD_BITS-1:0]      r;
      v_ext  = {v[IN_COORD_W-1], v};
      hi_ext = $signed({1'b0, IN_COORD_W'(hi)});
      if (v[IN_COORD_W-1]) begin
         r = '0;
      end else if (v_ext > hi_ext) begin
         r = hi;
      end else begin
         r = COORD_BITS'(v);
      end
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (load) begin
         left_ff   <= clamp_edge(in_left, screen_width);
         top_ff    <= clamp_edge(in_top, screen_height);
         right_ff  <= clamp_edge(in_right, screen_width);
         bottom_ff <= clamp_edge(in_bottom, screen_height);
      end
   end

   assign clip_left   = left_ff;
   assign clip_top    = top_ff;
   assign clip_right  = right_ff;
   assign clip_bottom = bottom_ff;
   assign empty       = (right_ff <= left_ff) || (bottom_ff <= top_ff);

endmodule

// File: hw/rtl/drc_rect_mem.sv
// Rectangle store: one write port and one registered read port.
module drc_rect_mem #(
   parameter int DEPTH  = 16,
   parameter int WIDTH  = 48,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
